// ===== hw/rtl/dbnc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the multi-button debouncer.
// Used by every module of the block; depends on nothing.
package dbnc_pkg;

  localparam int MASK_W = 8;

  typedef logic [7:0] count_t;
  typedef logic [1:0] event_kind_t;
  typedef logic [MASK_W-1:0] mask_t;

  localparam event_kind_t EV_NONE         = 2'd0;
  localparam event_kind_t EV_PRESS        = 2'd1;
  localparam event_kind_t EV_RELEASE      = 2'd2;
  localparam event_kind_t EV_HELD_RELEASE = 2'd3;

  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_HOLD_MASK = 1'b1;

  localparam count_t THRESHOLD_RESET = 8'd5;

  typedef struct packed {
    logic   last_sample;
    count_t agree_count;
    logic   stable_level;
  } entry_t;

  typedef struct packed {
    logic        wr_en;
    entry_t      entry;
    event_kind_t kind;
    mask_t       pressed;
  } upd_t;

endpackage

// ===== hw/rtl/dbnc_state_mem.sv =====
`timescale 1ns / 1ps
// Per-button state memory with a registered read, valid bits and write forwarding.
// Depends on dbnc_pkg.
module dbnc_state_mem #(
  parameter int BUTTON_COUNT = 8,
  parameter int IDX_W = 3
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output dbnc_pkg::entry_t rd_data,
  input  logic            wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  dbnc_pkg::entry_t wr_data
);

  dbnc_pkg::entry_t mem [BUTTON_COUNT];
  dbnc_pkg::entry_t mem_q;
  dbnc_pkg::entry_t byp_data;
  logic [BUTTON_COUNT-1:0] valid;
  logic byp_hit;
  logic rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      byp_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      byp_hit  <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        byp_hit  <= wr_en && (wr_addr == rd_addr);
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = byp_hit ? byp_data : (rd_valid ? mem_q : '0);

`ifndef SYNTH
  a_forward : assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en && (wr_addr == rd_addr)) |=> (rd_data == $past(wr_data)))
    else $error("state read does not see the write to the same entry");
`endif

endmodule

// ===== hw/rtl/dbnc_update.sv =====
`timescale 1ns / 1ps
// Read-modify-write logic: next state of one button, its event and the new pressed mask.
// Depends on dbnc_pkg.
module dbnc_update (
  input  dbnc_pkg::entry_t cur,
  input  logic             level,
  input  logic [2:0]       btn,
  input  logic             in_range,
  input  dbnc_pkg::count_t threshold,
  input  dbnc_pkg::mask_t  hold_mask,
  input  dbnc_pkg::mask_t  pressed,
  output dbnc_pkg::upd_t   upd
);

  dbnc_pkg::entry_t      nxt;
  dbnc_pkg::event_kind_t kind;
  dbnc_pkg::mask_t       pressed_next;
  dbnc_pkg::count_t      cnt_inc;

  assign cnt_inc = cur.agree_count + 8'd1;

  always_comb begin
    nxt          = cur;
    kind         = dbnc_pkg::EV_NONE;
    pressed_next = pressed;
    if (in_range) begin
      if (cur.last_sample == level) begin
        if (cur.agree_count < threshold) begin
          nxt.agree_count = cnt_inc;
          if ((cnt_inc == threshold) && (level != cur.stable_level)) begin
            nxt.stable_level = level;
            if (level) begin
              pressed_next[btn] = 1'b1;
              kind              = dbnc_pkg::EV_PRESS;
            end else begin
              pressed_next[btn] = 1'b0;
              kind = hold_mask[btn] ? dbnc_pkg::EV_HELD_RELEASE : dbnc_pkg::EV_RELEASE;
            end
          end
        end
      end else begin
        nxt.last_sample = level;
        nxt.agree_count = '0;
      end
    end
  end

  always_comb begin
    upd.wr_en   = in_range;
    upd.entry   = nxt;
    upd.kind    = kind;
    upd.pressed = pressed_next;
  end

endmodule

// ===== hw/rtl/multi_button_debouncer.sv =====
`timescale 1ns / 1ps
// Multi-button debouncer top level: stream ports, configuration and the request pipeline.
// Depends on dbnc_pkg, dbnc_state_mem and dbnc_update.
//
// Each request on the s_ side carries one raw sample: a button number and its level.
// Every accepted request produces exactly one result on the m_ side, in order: the
// event kind (none, press, release, release of a held action) in m_tuser, and the
// button number with the debounced pressed mask in m_tdata.
// A request passes the update stage and then the output register. One request is taken
// every cycle unless the receiver stalls, a rate set by the single read-modify-write of
// the per-button state memory, whose registered read is bridged by write forwarding. The
// cfg channel sets the debounce threshold (index 0) and the hold mask (index 1); it is
// always ready. The user must write it only while no request is in flight; the block
// does not enforce it. Reset sets the threshold to 5, clears the hold mask and the
// pressed mask, and marks every state entry as empty, so it reads as zero until first
// written. When the receiver stalls, the finished result waits in the output register and
// one more request is still taken into the update stage; after that s_tready falls.
module multi_button_debouncer #(
  parameter int BUTTON_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [2:0] button_number, [3] raw_level, [7:4] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [2:0] event_button, [10:3] pressed_mask, [15:11] zero
  output logic [1:0]  m_tuser,   // [1:0] event_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

  dbnc_pkg::count_t threshold;
  dbnc_pkg::mask_t  hold_mask;
  dbnc_pkg::mask_t  pressed;

  logic       s1_valid;
  logic [2:0] s1_btn;
  logic       s1_level;
  logic       s1_in_range;

  logic                  out_valid;
  dbnc_pkg::event_kind_t out_kind;
  logic [2:0]            out_btn;
  dbnc_pkg::mask_t       out_mask;

  logic             accept;
  logic             advance;
  dbnc_pkg::entry_t rd_entry;
  dbnc_pkg::upd_t   upd;

  assign advance  = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || advance;
  assign accept   = s_tvalid && s_tready;

  dbnc_state_mem #(
    .BUTTON_COUNT(BUTTON_COUNT),
    .IDX_W(IDX_W)
  ) u_mem (
    .clk(clk),
    .rst(rst),
    .rd_en(accept),
    .rd_addr(IDX_W'(s_tdata[2:0])),
    .rd_data(rd_entry),
    .wr_en(advance && upd.wr_en),
    .wr_addr(IDX_W'(s1_btn)),
    .wr_data(upd.entry)
  );

  dbnc_update u_update (
    .cur(rd_entry),
    .level(s1_level),
    .btn(s1_btn),
    .in_range(s1_in_range),
    .threshold(threshold),
    .hold_mask(hold_mask),
    .pressed(pressed),
    .upd(upd)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= dbnc_pkg::THRESHOLD_RESET;
      hold_mask <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dbnc_pkg::CFG_THRESHOLD: threshold <= cfg_data;
        dbnc_pkg::CFG_HOLD_MASK: hold_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      pressed   <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        pressed   <= upd.pressed;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_btn      <= s_tdata[2:0];
      s1_level    <= s_tdata[3];
      s1_in_range <= (32'(s_tdata[2:0]) < BUTTON_COUNT);
    end
    if (advance) begin
      out_kind <= upd.kind;
      out_btn  <= s1_btn;
      out_mask <= upd.pressed;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b0, out_mask, out_btn};
  assign m_tuser  = out_kind;

`ifndef SYNTH
  a_press_sets_bit : assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind == dbnc_pkg::EV_PRESS)) |-> out_mask[out_btn])
    else $error("press reported without its bit in the pressed mask");

  a_release_clears_bit : assert property (@(posedge clk) disable iff (rst)
    (out_valid && ((out_kind == dbnc_pkg::EV_RELEASE) ||
                   (out_kind == dbnc_pkg::EV_HELD_RELEASE))) |-> !out_mask[out_btn])
    else $error("release reported with its bit still in the pressed mask");

  a_held_needs_hold : assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind == dbnc_pkg::EV_HELD_RELEASE)) |-> hold_mask[out_btn])
    else $error("held release reported for a button without its hold bit");

  a_out_of_range_quiet : assert property (@(posedge clk) disable iff (rst)
    (out_valid && (32'(out_btn) >= BUTTON_COUNT)) |-> (out_kind == dbnc_pkg::EV_NONE))
    else $error("event reported for a button beyond the configured count");
`endif

endmodule

// ===== test/debounce_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the multi-button debouncer: watches the request, result and register
// channels, predicts every result from its own copy of the button state and compares.
// Depends on dbnc_pkg.
module debounce_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [2:0] button_number, [3] raw_level, [7:4] zero
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // [2:0] event_button, [10:3] pressed_mask, [15:11] zero
  input  logic [1:0]  m_tuser,   // [1:0] event_kind
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          outstanding
);

  typedef struct packed {
    dbnc_pkg::event_kind_t kind;
    logic [2:0]            button;
    dbnc_pkg::mask_t       pressed;
  } button_event_t;

  dbnc_pkg::count_t threshold;
  dbnc_pkg::mask_t  hold_bits;
  logic             prev_raw [8];
  dbnc_pkg::count_t agree [8];
  logic             settled [8];
  dbnc_pkg::mask_t  pressed_now;
  button_event_t    expected_events [$];

  function automatic button_event_t debounce_sample(logic [2:0] btn, logic level);
    button_event_t ev;
    ev.kind = dbnc_pkg::EV_NONE;
    ev.button = btn;
    if (prev_raw[btn] != level) begin
      prev_raw[btn] = level;
      agree[btn] = '0;
    end else if (agree[btn] < threshold) begin
      agree[btn] = agree[btn] + 8'd1;
      if (agree[btn] == threshold && level != settled[btn]) begin
        settled[btn] = level;
        pressed_now[btn] = level;
        if (level) begin
          ev.kind = dbnc_pkg::EV_PRESS;
        end else if (hold_bits[btn]) begin
          ev.kind = dbnc_pkg::EV_HELD_RELEASE;
        end else begin
          ev.kind = dbnc_pkg::EV_RELEASE;
        end
      end
    end
    ev.pressed = pressed_now;
    return ev;
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= 100) begin
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    button_event_t want;
    if (rst) begin
      fail_count = 0;
      threshold = dbnc_pkg::THRESHOLD_RESET;
      hold_bits = '0;
      pressed_now = '0;
      for (int b = 0; b < 8; b++) begin
        prev_raw[b] = 1'b0;
        agree[b] = '0;
        settled[b] = 1'b0;
      end
      expected_events.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_events.size() == 0) begin
          fail_count++;
          if (fail_count <= 100) begin
            $display("%0t: result expected none actual kind %0d button %0d mask %0d",
                     $time, m_tuser, m_tdata[2:0], m_tdata[10:3]);
          end
        end else begin
          want = expected_events.pop_front();
          check_field("event_kind", int'(want.kind), int'(m_tuser));
          check_field("event_button", int'(want.button), int'(m_tdata[2:0]));
          check_field("pressed_mask", int'(want.pressed), int'(m_tdata[10:3]));
        end
      end
      if (s_tvalid && s_tready) begin
        expected_events.push_back(debounce_sample(s_tdata[2:0], s_tdata[3]));
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == dbnc_pkg::CFG_THRESHOLD) begin
          threshold = cfg_data;
        end else begin
          hold_bits = cfg_data;
        end
      end
    end
    outstanding <= expected_events.size();
  end

endmodule

// ===== test/tb_multi_button_debouncer.sv =====
`timescale 1ns / 1ps
// Testbench top for the multi-button debouncer: clock, reset, sample requests,
// register writes and a randomly stalling receiver; the verdict comes from debounce_checker.
// Depends on dbnc_pkg, multi_button_debouncer and debounce_checker.
module tb_multi_button_debouncer;

  localparam int CYCLE_LIMIT = 200000;
  localparam int FOCUS_RUN = 262;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = dbnc_pkg::CFG_THRESHOLD;
  logic [7:0]  cfg_data = '0;
  int          fail_count;
  int          outstanding;
  int          cycles = 0;
  logic        intent [8];
  logic        tx_steady = 1'b0;
  logic        rx_steady = 1'b0;
  int          rx_wait = 0;

  multi_button_debouncer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  debounce_checker scoreboard (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .fail_count(fail_count), .outstanding(outstanding)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_multi_button_debouncer NOT OK");
      $finish;
    end
  end

  // After each result the receiver may stall for a randomly drawn wait, unless it is in a steady phase.
  always @(posedge clk) begin
    logic ready_next;
    if (rst) begin
      ready_next = 1'b0;
    end else begin
      if ($urandom_range(0, 49) == 0) rx_steady = !rx_steady;
      if (m_tvalid && m_tready) rx_wait = rx_steady ? 0 : $urandom_range(0, 6);
      ready_next = (rx_wait == 0);
      if (rx_wait > 0) rx_wait--;
    end
    m_tready <= ready_next;
  end

  task automatic send_sample(input logic [2:0] btn, input logic level);
    int gap;
    if ($urandom_range(0, 29) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0000, level, btn};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input int thr, input int hold);
    cfg_valid <= 1'b1;
    cfg_index <= dbnc_pkg::CFG_THRESHOLD;
    cfg_data <= 8'(thr);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= dbnc_pkg::CFG_HOLD_MASK;
    cfg_data <= 8'(hold);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Each button follows an intended level that changes now and then, with bounce on top.
  task automatic random_phase(input int thr, input int hold, input int count,
                              input int bounce_pct);
    logic [2:0] btn;
    logic       level;
    drain();
    write_config(thr, hold);
    repeat (count) begin
      btn = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 2 * thr + 3) == 0) intent[btn] = !intent[btn];
      level = intent[btn];
      if ($urandom_range(0, 99) < bounce_pct) level = !level;
      send_sample(btn, level);
    end
  endtask

  initial begin
    int k;
    for (int b = 0; b < 8; b++) intent[b] = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    repeat (6) send_sample(3'd2, 1'b1);
    drain();
    write_config(1, 8'hAA);
    repeat (3) send_sample(3'd0, 1'b1);
    repeat (2) send_sample(3'd0, 1'b0);
    repeat (2) send_sample(3'd7, 1'b1);
    repeat (2) send_sample(3'd7, 1'b0);
    send_sample(3'd4, 1'b1);
    send_sample(3'd4, 1'b0);
    repeat (2) send_sample(3'd4, 1'b1);
    send_sample(3'd5, 1'b0);
    repeat (2) send_sample(3'd2, 1'b0);
    repeat (2) send_sample(3'd3, 1'b1);
    repeat (2) send_sample(3'd3, 1'b0);

    random_phase(1, 8'hFF, 150, 15);
    random_phase(2, 8'h00, 150, 10);
    random_phase(8, $urandom_range(0, 255), 120, 5);
    random_phase(3, $urandom_range(0, 255), 140, 10);

    // Longest threshold: one button held long enough to press and release.
    drain();
    write_config(255, 8'h80);
    k = 0;
    while (k < 2 * FOCUS_RUN) begin
      if ($urandom_range(0, 9) == 0) begin
        send_sample(3'($urandom_range(0, 6)), 1'($urandom_range(0, 1)));
      end else begin
        send_sample(3'd7, k < FOCUS_RUN);
        k++;
      end
    end

    random_phase(4, 8'h55, 140, 10);
    random_phase($urandom_range(1, 255), $urandom_range(0, 255), 100, 5);
    random_phase($urandom_range(1, 6), $urandom_range(0, 255), 150, 10);
    drain();
    repeat (10) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb_multi_button_debouncer OK");
    end else begin
      $display("tb_multi_button_debouncer NOT OK");
    end
    $finish;
  end

endmodule
